// ===== hdl/mhu_pkg.sv =====
// Shared types, constants and the CORDIC arctangent table for the
// magnetometer heading unit. No dependencies.
package mhu_pkg;

  // Field and datapath widths.
  localparam int FIELD_W    = 20;
  localparam int HEAD_W     = 16;
  localparam int DEC_W      = 16;
  localparam int DW         = 32;   // CORDIC vector and angle width
  localparam int PRESHIFT   = 8;    // start vector is field * 256
  localparam int TABLE_LEN  = 24;

  // Angles are in units of 1/65536 centidegree.
  localparam logic signed [DW-1:0] ANG_90   = 32'sd589824000;
  localparam logic signed [DW-1:0] ANG_HALF = 32'sd32768;

  // Heading arithmetic in centidegrees.
  localparam logic signed [HEAD_W:0]   HEAD_OFFSET = 17'sd9000;
  localparam logic signed [HEAD_W:0]   TURN_17     = 17'sd36000;
  localparam logic signed [HEAD_W+1:0] TURN_18     = 18'sd36000;
  localparam logic signed [DEC_W-1:0]  DEC_MAX     = 16'sd18000;
  localparam logic signed [DEC_W-1:0]  DEC_MIN     = -16'sd18000;
  localparam logic [HEAD_W-1:0]        HEAD_LIMIT  = 16'd36000;

  typedef logic signed [FIELD_W-1:0] field_t;
  typedef logic signed [DW-1:0]      vec_t;
  typedef logic [HEAD_W-1:0]         head_t;

  // round(atan(2^-i) in degrees * 6553600)
  function automatic vec_t atan_entry(input int idx);
    vec_t val;
    case (idx)
      0:       val = 32'sd294912000;
      1:       val = 32'sd174096719;
      2:       val = 32'sd91987925;
      3:       val = 32'sd46694507;
      4:       val = 32'sd23437865;
      5:       val = 32'sd11730358;
      6:       val = 32'sd5866610;
      7:       val = 32'sd2933484;
      8:       val = 32'sd1466764;
      9:       val = 32'sd733385;
      10:      val = 32'sd366693;
      11:      val = 32'sd183346;
      12:      val = 32'sd91673;
      13:      val = 32'sd45837;
      14:      val = 32'sd22918;
      15:      val = 32'sd11459;
      16:      val = 32'sd5730;
      17:      val = 32'sd2865;
      18:      val = 32'sd1432;
      19:      val = 32'sd716;
      20:      val = 32'sd358;
      21:      val = 32'sd179;
      22:      val = 32'sd90;
      23:      val = 32'sd45;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// ===== hdl/magnetometer_heading_unit_top.sv =====
// Top level of the magnetometer heading unit: byte assembly, CORDIC atan2
// pipeline, heading wrap and declination correction. Depends on mhu_pkg.
//
//  Channel  | Handshake              | Payload
//  ---------+------------------------+---------------------------------------
//  input    | in_valid / in_ready    | nine raw register bytes of one sample
//  output   | out_valid / out_ready  | x/y/z field counts, heading_centideg
//  config   | cfg_wr_en (no wait)    | cfg_wr_data = declination_centideg
//
// One beat enters per cycle and one result leaves per cycle while the output
// side takes them. The stages are an input register, a pre-rotation stage,
// one stage per CORDIC iteration, a rounding stage and the declination
// stage, which is also the output register.
// The whole pipeline advances together; it holds when the output register is
// full and not taken, so a stall neither drops nor repeats a beat.
// Reset clears all valid bits and sets the declination to zero.
module magnetometer_heading_unit_top #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [mhu_pkg::DEC_W-1:0] cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                x_high_byte,
  input  logic [7:0]                x_mid_byte,
  input  logic [7:0]                y_high_byte,
  input  logic [7:0]                y_mid_byte,
  input  logic [7:0]                z_high_byte,
  input  logic [7:0]                z_mid_byte,
  input  logic [7:0]                x_low_byte,
  input  logic [7:0]                y_low_byte,
  input  logic [7:0]                z_low_byte,
  output logic                      out_valid,
  input  logic                      out_ready,
  output mhu_pkg::field_t           x_field,
  output mhu_pkg::field_t           y_field,
  output mhu_pkg::field_t           z_field,
  output mhu_pkg::head_t            heading_centideg
);
  import mhu_pkg::*;

  // The arctangent table has only TABLE_LEN entries.
  localparam int NITER = (CORDIC_ITERATIONS > TABLE_LEN) ? TABLE_LEN : CORDIC_ITERATIONS;

  // Pipeline advance: everything moves unless a finished result is waiting.
  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Declination register, saturated to half a turn on write so that one
  // wrap after the subtraction always lands inside a full turn.
  logic signed [DEC_W-1:0] dec;
  logic signed [DEC_W-1:0] cfg_sat;

  always_comb begin
    cfg_sat = $signed(cfg_wr_data);
    if (cfg_sat > DEC_MAX) begin
      cfg_sat = DEC_MAX;
    end else if (cfg_sat < DEC_MIN) begin
      cfg_sat = DEC_MIN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec <= '0;
    end else if (cfg_wr_en) begin
      dec <= cfg_sat;
    end
  end

  // Input register. Removing the zero offset of 2^19 from the unsigned
  // 20-bit count is the same as flipping its top bit.
  logic   in_v;
  field_t in_x, in_y, in_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (adv) begin
      in_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_x <= $signed({~x_high_byte[7], x_high_byte[6:0], x_mid_byte, x_low_byte[7:4]});
      in_y <= $signed({~y_high_byte[7], y_high_byte[6:0], y_mid_byte, y_low_byte[7:4]});
      in_z <= $signed({~z_high_byte[7], z_high_byte[6:0], z_mid_byte, z_low_byte[7:4]});
    end
  end

  // CORDIC pipeline registers; index 0 holds the pre-rotated start vector and
  // index k+1 the result of iteration k.
  logic   cv   [0:NITER];
  logic   czero[0:NITER];
  vec_t   ca   [0:NITER];
  vec_t   cb   [0:NITER];
  vec_t   cang [0:NITER];
  field_t cx   [0:NITER];
  field_t cy   [0:NITER];
  field_t cz   [0:NITER];

  // Start vector a = y * 256, b = -x * 256, then rotate into the right half
  // plane so that the iterations converge.
  vec_t start_a, start_b, pre_a, pre_b, pre_ang;

  always_comb begin
    start_a = {{(DW-FIELD_W-PRESHIFT){in_y[FIELD_W-1]}}, in_y, {PRESHIFT{1'b0}}};
    start_b = -{{(DW-FIELD_W-PRESHIFT){in_x[FIELD_W-1]}}, in_x, {PRESHIFT{1'b0}}};
    pre_a   = start_a;
    pre_b   = start_b;
    pre_ang = '0;
    if (start_a < 0) begin
      if (start_b >= 0) begin
        pre_a   = start_b;
        pre_b   = -start_a;
        pre_ang = ANG_90;
      end else begin
        pre_a   = -start_b;
        pre_b   = start_a;
        pre_ang = -ANG_90;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else if (adv) begin
      cv[0] <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      czero[0] <= (in_x == '0) && (in_y == '0);
      ca[0]    <= pre_a;
      cb[0]    <= pre_b;
      cang[0]  <= pre_ang;
      cx[0]    <= in_x;
      cy[0]    <= in_y;
      cz[0]    <= in_z;
    end
  end

  // One vectoring iteration per stage; the shifts are fixed per stage.
  for (genvar k = 0; k < NITER; k++) begin : g_iter
    always_ff @(posedge clk) begin
      if (rst) begin
        cv[k+1] <= 1'b0;
      end else if (adv) begin
        cv[k+1] <= cv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        if (cb[k] >= 0) begin
          ca[k+1]   <= ca[k] + (cb[k] >>> k);
          cb[k+1]   <= cb[k] - (ca[k] >>> k);
          cang[k+1] <= cang[k] + atan_entry(k);
        end else begin
          ca[k+1]   <= ca[k] - (cb[k] >>> k);
          cb[k+1]   <= cb[k] + (ca[k] >>> k);
          cang[k+1] <= cang[k] - atan_entry(k);
        end
        czero[k+1] <= czero[k];
        cx[k+1]    <= cx[k];
        cy[k+1]    <= cy[k];
        cz[k+1]    <= cz[k];
      end
    end
  end

  // Rounding stage: half-up rounding to centidegrees, plus a quarter turn,
  // wrapped into one turn. A zero vector has an arctangent of zero.
  vec_t                     ang_rnd;
  logic signed [HEAD_W-1:0] ang_cd;
  logic signed [HEAD_W:0]   head_raw;
  head_t                    head_wrap;

  always_comb begin
    ang_rnd  = cang[NITER] + ANG_HALF;
    ang_cd   = czero[NITER] ? '0 : $signed(ang_rnd[DW-1:DW-HEAD_W]);
    head_raw = {ang_cd[HEAD_W-1], ang_cd} + HEAD_OFFSET;
    if (head_raw < 0) begin
      head_raw = head_raw + TURN_17;
    end else if (head_raw >= TURN_17) begin
      head_raw = head_raw - TURN_17;
    end
    head_wrap = head_raw[HEAD_W-1:0];
  end

  logic   rv;
  head_t  rhead;
  field_t rx, ry, rz;

  always_ff @(posedge clk) begin
    if (rst) begin
      rv <= 1'b0;
    end else if (adv) begin
      rv <= cv[NITER];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rhead <= head_wrap;
      rx    <= cx[NITER];
      ry    <= cy[NITER];
      rz    <= cz[NITER];
    end
  end

  // Declination stage and output register.
  logic signed [HEAD_W+1:0] true_raw;

  always_comb begin
    true_raw = $signed({2'b00, rhead}) - {{2{dec[DEC_W-1]}}, dec};
    if (true_raw >= TURN_18) begin
      true_raw = true_raw - TURN_18;
    end else if (true_raw < 0) begin
      true_raw = true_raw + TURN_18;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= rv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      heading_centideg <= true_raw[HEAD_W-1:0];
      x_field          <= rx;
      y_field          <= ry;
      z_field          <= rz;
    end
  end

  // The heading leaving the block always lies within one turn.
  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> heading_centideg < HEAD_LIMIT)
    else $error("heading outside one turn");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // While the output is stalled the interior stages keep their beats.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(cv[0]) && $stable(cv[NITER]) && $stable(rv) && $stable(rhead))
    else $error("pipeline moved during a stall");

  // The stored declination never leaves the saturated range.
  a_dec_range: assert property (@(posedge clk) disable iff (rst)
    dec <= DEC_MAX && dec >= DEC_MIN)
    else $error("declination register out of range");

endmodule
